// File: hw/rtl/dq_pkg.sv
// shared types and codes for the bounded deque
// used by the controller, the datapath and the checker; depends on nothing

package dq_pkg;

  // operation codes carried by the kind field
  typedef enum logic [2:0] {
    KIND_PUSH_BACK  = 3'd0,
    KIND_PUSH_FRONT = 3'd1,
    KIND_POP_BACK   = 3'd2,
    KIND_POP_FRONT  = 3'd3,
    KIND_READ_AT    = 3'd4
  } kind_e;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_RANGE = 2'd3;

  // which offset from the front pointer forms the memory address
  typedef enum logic [2:0] {
    OFF_ZERO  = 3'd0,
    OFF_COUNT = 3'd1,
    OFF_LAST  = 3'd2,
    OFF_IDX   = 3'd3,
    OFF_RIDX  = 3'd4,
    OFF_PREV  = 3'd5
  } offs_e;

  // front pointer update
  typedef enum logic [1:0] {
    PTR_KEEP = 2'd0,
    PTR_DEC  = 2'd1,
    PTR_INC  = 2'd2
  } ptr_e;

  // entry count update
  typedef enum logic [1:0] {
    CNT_KEEP = 2'd0,
    CNT_INC  = 2'd1,
    CNT_DEC  = 2'd2
  } cnt_e;

  // commands from controller to datapath
  typedef struct packed {
    logic       mem_en;
    logic       mem_we;
    offs_e      offs_sel;
    ptr_e       ptr_upd;
    cnt_e       cnt_upd;
    logic       load_resp;
    logic       take_read;
    logic [1:0] code;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic full;
    logic empty;
    logic idx_ok;
  } dp_sts_t;

endpackage

// File: hw/rtl/dq_ram.sv
// generic single-port ram with registered read data
// no dependencies

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one access per cycle, write or read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/dq_ctrl.sv
// controller: decodes each item into datapath commands and sequences the result strobe
// depends on dq_pkg

module dq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic [2:0]      kind_i,
  input  logic            from_front_i,
  input  dq_pkg::dp_sts_t sts_i,
  output dq_pkg::dp_cmd_t cmd_o,
  output logic            busy,
  output logic            done_o
);

  import dq_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RESP = 2'b10
  } state_e;

  state_e  state_q, state_d;
  logic    accept;
  kind_e   kind;
  dp_cmd_t cmd;

  // the deque never holds an item off
  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign kind   = kind_e'(kind_i);

  // the result strobe is raised in the cycle after each accepted item
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  state_d = accept ? S_RESP : S_IDLE;
      S_RESP:  state_d = accept ? S_RESP : S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign done_o = (state_q == S_RESP);

  // operation decode
  always_comb begin
    cmd           = '0;
    cmd.offs_sel  = OFF_ZERO;
    cmd.ptr_upd   = PTR_KEEP;
    cmd.cnt_upd   = CNT_KEEP;
    cmd.code      = ST_OK;
    cmd.load_resp = accept;
    if (accept) begin
      case (kind)
        KIND_PUSH_BACK: begin
          if (sts_i.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.mem_en   = 1'b1;
            cmd.mem_we   = 1'b1;
            cmd.offs_sel = OFF_COUNT;
            cmd.cnt_upd  = CNT_INC;
          end
        end
        KIND_PUSH_FRONT: begin
          if (sts_i.full) begin
            cmd.code = ST_FULL;
          end else begin
            cmd.mem_en   = 1'b1;
            cmd.mem_we   = 1'b1;
            cmd.offs_sel = OFF_PREV;
            cmd.ptr_upd  = PTR_DEC;
            cmd.cnt_upd  = CNT_INC;
          end
        end
        KIND_POP_BACK: begin
          if (sts_i.empty) begin
            cmd.code = ST_EMPTY;
          end else begin
            cmd.mem_en    = 1'b1;
            cmd.offs_sel  = OFF_LAST;
            cmd.cnt_upd   = CNT_DEC;
            cmd.take_read = 1'b1;
          end
        end
        KIND_POP_FRONT: begin
          if (sts_i.empty) begin
            cmd.code = ST_EMPTY;
          end else begin
            cmd.mem_en    = 1'b1;
            cmd.offs_sel  = OFF_ZERO;
            cmd.ptr_upd   = PTR_INC;
            cmd.cnt_upd   = CNT_DEC;
            cmd.take_read = 1'b1;
          end
        end
        KIND_READ_AT: begin
          if (!sts_i.idx_ok) begin
            cmd.code = ST_RANGE;
          end else begin
            cmd.mem_en    = 1'b1;
            cmd.offs_sel  = from_front_i ? OFF_IDX : OFF_RIDX;
            cmd.take_read = 1'b1;
          end
        end
        default: begin
          cmd.code = ST_OK;
        end
      endcase
    end
  end

  assign cmd_o = cmd;

endmodule

// File: hw/rtl/dq_datapath.sv
// datapath: front pointer, entry count, ring address arithmetic, element ram, result registers
// depends on dq_pkg and dq_ram

module dq_datapath #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  dq_pkg::dp_cmd_t cmd_i,
  input  logic [31:0]     write_value_i,
  input  logic [5:0]      index_i,
  output dq_pkg::dp_sts_t sts_o,
  output logic [31:0]     read_value_o,
  output logic [6:0]      entry_count_o,
  output logic [1:0]      status_o
);

  import dq_pkg::*;

  localparam int PW  = $clog2(DEPTH);
  localparam int CW  = $clog2(DEPTH + 1);
  localparam int IXW = (CW > 6) ? CW : 6;
  localparam int XW  = (ELEMENT_WIDTH > 32) ? ELEMENT_WIDTH : 32;
  localparam logic [PW:0]   DEPTH_W = (PW + 1)'(DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] PREV_OFF = PW'(DEPTH - 1);

  logic [PW-1:0] front_q, front_d;
  logic [CW-1:0] count_q, count_d;
  logic [1:0]    status_q;
  logic          take_read_q;

  logic [CW-1:0] last_cnt, ridx_cnt;
  logic [PW-1:0] offset, slot, front_inc;
  logic [PW:0]   slot_sum, inc_sum;
  logic [XW-1:0] wv_ext, rd_ext;
  logic [ELEMENT_WIDTH-1:0] wr_data, rd_data;

  // status towards the controller
  assign sts_o.full   = (count_q == DEPTH_C);
  assign sts_o.empty  = (count_q == '0);
  assign sts_o.idx_ok = IXW'(index_i) < IXW'(count_q);

  // offset from the front entry
  assign last_cnt = count_q - CW'(1);
  assign ridx_cnt = last_cnt - CW'(index_i);

  always_comb begin
    case (cmd_i.offs_sel)
      OFF_ZERO:  offset = '0;
      OFF_COUNT: offset = PW'(count_q);
      OFF_LAST:  offset = PW'(last_cnt);
      OFF_IDX:   offset = PW'(index_i);
      OFF_RIDX:  offset = PW'(ridx_cnt);
      OFF_PREV:  offset = PREV_OFF;
      default:   offset = '0;
    endcase
  end

  // ring slot, both operands below depth so one conditional subtract wraps it
  assign slot_sum = {1'b0, front_q} + {1'b0, offset};
  assign slot     = (slot_sum >= DEPTH_W) ? PW'(slot_sum - DEPTH_W) : PW'(slot_sum);
  assign inc_sum  = {1'b0, front_q} + (PW + 1)'(1);
  assign front_inc = (inc_sum >= DEPTH_W) ? PW'(inc_sum - DEPTH_W) : PW'(inc_sum);

  // pointer and count updates
  always_comb begin
    case (cmd_i.ptr_upd)
      PTR_DEC: front_d = slot;
      PTR_INC: front_d = front_inc;
      default: front_d = front_q;
    endcase
    case (cmd_i.cnt_upd)
      CNT_INC: count_d = count_q + CW'(1);
      CNT_DEC: count_d = count_q - CW'(1);
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
    end
  end

  // result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_resp) begin
      status_q    <= cmd_i.code;
      take_read_q <= cmd_i.take_read;
    end
  end

  // element width adaptation
  assign wv_ext  = XW'(write_value_i);
  assign wr_data = wv_ext[ELEMENT_WIDTH-1:0];

  dq_ram #(
    .WIDTH (ELEMENT_WIDTH),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (cmd_i.mem_en),
    .we_i    (cmd_i.mem_we),
    .addr_i  (slot),
    .wdata_i (wr_data),
    .rdata_o (rd_data)
  );

  assign rd_ext        = XW'(rd_data);
  assign read_value_o  = take_read_q ? rd_ext[31:0] : 32'd0;
  assign entry_count_o = 7'(count_q);
  assign status_o      = status_q;

endmodule

// File: hw/rtl/bounded_deque_with_index.sv
// bounded deque with indexed read: ring buffer in a single-port ram
// result strobe on done_o in the cycle after the item is accepted
// throughput: one item per cycle, busy stays low; one ram access per item sets this
// the receiver cannot stall, each result is shown for exactly one cycle
// reset clears the front pointer and entry count at once; the ram needs no clearing pass
// depends on dq_pkg, dq_ctrl, dq_datapath, dq_ram

module bounded_deque_with_index #(
  parameter int DEPTH         = 64,
  parameter int ELEMENT_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  kind_i,
  input  logic [31:0] write_value_i,
  input  logic [5:0]  index_i,
  input  logic        from_front_i,
  output logic        done_o,
  output logic [31:0] read_value_o,
  output logic [6:0]  entry_count_o,
  output logic [1:0]  status_o
);

  import dq_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  // operation decode and result sequencing
  dq_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .kind_i       (kind_i),
    .from_front_i (from_front_i),
    .sts_i        (sts),
    .cmd_o        (cmd),
    .busy         (busy),
    .done_o       (done_o)
  );

  // storage and address arithmetic
  dq_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .write_value_i (write_value_i),
    .index_i       (index_i),
    .sts_o         (sts),
    .read_value_o  (read_value_o),
    .entry_count_o (entry_count_o),
    .status_o      (status_o)
  );

endmodule

// File: hw/rtl/dq_checker.sv
// port-level checks for the bounded deque, bound to the top level
// depends on dq_pkg

module dq_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        done_o,
  input logic [31:0] read_value_o,
  input logic [6:0]  entry_count_o,
  input logic [1:0]  status_o
);

  import dq_pkg::*;

  localparam logic [6:0] FULL_CNT = 7'(DEPTH);

  // every accepted item gives a result in the next cycle
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> done_o)
    else $error("no result after accepted item");

  // no result without an item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |=> !done_o)
    else $error("result without accepted item");

  // failed operations return zero
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (read_value_o == 32'd0))
    else $error("non-zero value on failed operation");

  // full refusal only at capacity
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_FULL)) |-> (entry_count_o == FULL_CNT))
    else $error("full status below capacity");

  // empty refusal only with no entries
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_EMPTY)) |-> (entry_count_o == 7'd0))
    else $error("empty status with entries held");

endmodule

bind bounded_deque_with_index dq_checker #(.DEPTH(DEPTH)) u_dq_checker (.*);
